// File: src/pcfs_pkg.sv
// Shared types, constants and helper functions of the periodic CAN frame scheduler.
package pcfs_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned ID_W        = 29;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned PER_W       = 32;
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned INT_W       = PER_W + MS_W;
  localparam int unsigned MAX_LEN     = 8;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned IN_TDATA_W  = 200;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP
  } cmd_kind_e;

  // One classified item as it waits in the queue between front and back.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_us;
    logic [ID_W-1:0]   frame_id;
    logic              extended;
    logic [LEN_W-1:0]  data_len;
    logic [DATA_W-1:0] data_bytes;
    logic [PER_W-1:0]  period_ms;
  } cmd_t;

  // One due frame on its way out.
  typedef struct packed {
    logic [SLOT_W-1:0] due_slot;
    logic [ID_W-1:0]   out_id;
    logic              out_extended;
    logic [LEN_W-1:0]  out_len;
    logic [DATA_W-1:0] out_data;
    logic              last;
  } res_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
    return res;
  endfunction

  // Clears every payload byte at or above the given length.
  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                   input logic [LEN_W-1:0]  len);
    logic [DATA_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < int'(MAX_LEN); b++) begin
      mask[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
    end
    return data & mask;
  endfunction

endpackage

// File: src/pcfs_front.sv
// Input side: accepts beats, sorts out items that do nothing and queues the rest.
module pcfs_front
  import pcfs_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  in_action_i,
  input  logic [SLOT_W-1:0] in_slot_i,
  input  logic [TIME_W-1:0] in_now_us_i,
  input  logic [ID_W-1:0]   in_frame_id_i,
  input  logic              in_extended_i,
  input  logic [LEN_W-1:0]  in_data_len_i,
  input  logic [DATA_W-1:0] in_data_bytes_i,
  input  logic [PER_W-1:0]  in_period_ms_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  localparam int unsigned QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  cmd_t           q_mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;

  cmd_t       cmd_new;
  logic       keep;
  logic       slot_ok;
  logic       push;
  logic       pop;
  logic [LEN_W-1:0] len_c;

  assign slot_ok = {{(32-SLOT_W){1'b0}}, in_slot_i} < 32'(SLOTS);
  assign len_c   = clamp_len(in_data_len_i);

  always_comb begin
    cmd_new            = '0;
    cmd_new.slot       = in_slot_i;
    cmd_new.now_us     = in_now_us_i;
    cmd_new.frame_id   = in_frame_id_i;
    cmd_new.extended   = in_extended_i;
    cmd_new.data_len   = len_c;
    cmd_new.data_bytes = keep_bytes(in_data_bytes_i, len_c);
    cmd_new.period_ms  = in_period_ms_i;
    keep               = 1'b0;
    case (in_action_i)
      ACT_TICK: begin
        cmd_new.kind = CMD_TICK;
        keep         = 1'b1;
      end
      ACT_START: begin
        cmd_new.kind = CMD_START;
        keep         = slot_ok;
      end
      ACT_STOP: begin
        cmd_new.kind = CMD_STOP;
        keep         = slot_ok;
      end
      default: begin
        cmd_new.kind = CMD_TICK;
        keep         = 1'b0;
      end
    endcase
  end

  // Items that change nothing are still taken, they are just not queued.
  assign in_ready_o  = cnt_q != QCW'(QDEPTH);
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: src/pcfs_back.sv
// Execution side: slot table, scan pipeline for ticks and the output register.
module pcfs_back
  import pcfs_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              ext;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [PER_W-1:0]  period;
  } entry_t;

  entry_t            frame_mem [SLOTS];
  logic [TIME_W-1:0] last_mem  [SLOTS];

  state_e            state_q;
  logic [SLOTS-1:0]  active_q;
  logic [SLOTS-1:0]  last_vld_q;
  logic [TIME_W-1:0] now_q;
  logic [CW-1:0]     rd_cnt_q;

  logic              s1_vld_q;
  logic [SW-1:0]     s1_idx_q;
  logic              s1_act_q;
  logic              s1_lvld_q;
  entry_t            s1_ent_q;
  logic [TIME_W-1:0] s1_last_q;

  logic              s2_vld_q;
  logic [SW-1:0]     s2_idx_q;
  logic              s2_act_q;
  entry_t            s2_ent_q;
  logic [TIME_W-1:0] s2_elapsed_q;
  logic [INT_W-1:0]  s2_interval_q;

  logic              pend_vld_q;
  res_t              pend_q;
  logic              out_vld_q;
  res_t              out_q;

  logic              out_free;
  logic              s2_due;
  logic              advance;
  logic              issue;
  logic              drained;
  logic              cmd_fire;
  logic [SW-1:0]     rd_idx;
  logic [SW-1:0]     wr_idx;
  entry_t            wr_ent;
  res_t              s2_res;
  res_t              pend_mid;
  res_t              pend_end;

  assign out_free = !out_vld_q || out_ready_i;
  assign s2_due   = s2_vld_q && s2_act_q && (s2_elapsed_q >= TIME_W'(s2_interval_q));
  // A due frame can only be parked once the one before it has moved to the output.
  assign advance  = !(s2_due && pend_vld_q && !out_free);
  assign rd_idx   = rd_cnt_q[SW-1:0];
  assign issue    = (state_q == ST_SCAN) && advance && (rd_cnt_q < CW'(SLOTS));
  assign drained  = (state_q == ST_SCAN) && (rd_cnt_q == CW'(SLOTS)) && !s1_vld_q && !s2_vld_q;

  assign cmd_ready_o = state_q == ST_IDLE;
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;
  assign wr_idx      = SW'(cmd_i.slot);

  always_comb begin
    wr_ent.id     = cmd_i.frame_id;
    wr_ent.ext    = cmd_i.extended;
    wr_ent.len    = cmd_i.data_len;
    wr_ent.data   = cmd_i.data_bytes;
    wr_ent.period = cmd_i.period_ms;

    s2_res.due_slot     = SLOT_W'(s2_idx_q);
    s2_res.out_id       = s2_ent_q.id;
    s2_res.out_extended = s2_ent_q.ext;
    s2_res.out_len      = s2_ent_q.len;
    s2_res.out_data     = s2_ent_q.data;
    s2_res.last         = 1'b0;

    pend_mid      = pend_q;
    pend_mid.last = 1'b0;
    pend_end      = pend_q;
    pend_end.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire && cmd_i.kind == CMD_START) begin
      frame_mem[wr_idx] <= wr_ent;
    end
    if (issue) begin
      s1_ent_q <= frame_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_due) begin
      last_mem[s2_idx_q] <= now_q;
    end
    if (issue) begin
      s1_last_q <= last_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_q      <= '0;
      last_vld_q    <= '0;
      now_q         <= '0;
      rd_cnt_q      <= '0;
      s1_vld_q      <= 1'b0;
      s1_idx_q      <= '0;
      s1_act_q      <= 1'b0;
      s1_lvld_q     <= 1'b0;
      s2_vld_q      <= 1'b0;
      s2_idx_q      <= '0;
      s2_act_q      <= 1'b0;
      s2_ent_q      <= '0;
      s2_elapsed_q  <= '0;
      s2_interval_q <= '0;
      pend_vld_q    <= 1'b0;
      pend_q        <= '0;
      out_vld_q     <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              CMD_START: active_q[wr_idx] <= 1'b1;
              CMD_STOP:  active_q[wr_idx] <= 1'b0;
              CMD_TICK: begin
                now_q    <= cmd_i.now_us;
                rd_cnt_q <= '0;
                state_q  <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + CW'(1);
          end
          if (drained) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          // The frame still parked is the final one of this tick.
          if (!pend_vld_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q      <= pend_end;
            out_vld_q  <= 1'b1;
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (advance) begin
        s1_vld_q <= issue;
        if (issue) begin
          s1_idx_q  <= rd_idx;
          s1_act_q  <= active_q[rd_idx];
          s1_lvld_q <= last_vld_q[rd_idx];
        end
        s2_vld_q      <= s1_vld_q;
        s2_idx_q      <= s1_idx_q;
        s2_act_q      <= s1_act_q;
        s2_ent_q      <= s1_ent_q;
        s2_elapsed_q  <= now_q - (s1_lvld_q ? s1_last_q : '0);
        s2_interval_q <= INT_W'(s1_ent_q.period) * INT_W'(US_PER_MS);
      end

      if (advance && s2_due) begin
        last_vld_q[s2_idx_q] <= 1'b1;
        if (pend_vld_q) begin
          out_q     <= pend_mid;
          out_vld_q <= 1'b1;
        end
        pend_q     <= s2_res;
        pend_vld_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// File: src/periodic_can_frame_scheduler.sv
// Top level of the periodic CAN frame scheduler: stream ports and beat packing.
//
// Input stream (s_axis): each beat is one item. tuser carries the action (tick, start slot,
// stop slot); tdata carries the slot index, the current time in microseconds and the frame
// to be stored. Start and stop items with a slot index beyond the table, and the unused
// action code, are taken and have no effect.
// Output stream (m_axis): one beat per due frame, in ascending slot order; tlast marks the
// final frame of a tick. A tick with no due slot gives no beat.
// Items pass a two-entry queue into the execution side, which handles one item at a time.
// Start stores the frame and sets the slot's active flag there; stop clears the flag. A tick
// scans the table one slot per cycle through a read and compare pipeline, pausing while a
// parked due frame cannot move on to the output. A due frame is held back until the next
// due frame or the end of the scan is found, which is how tlast is known.
// When the receiver stalls, the output register and one parked frame fill and the scan
// pauses; further items wait in the queue and s_axis_tready falls once it is full.
// Reset clears all active flags and the valid flags of the last-send times and empties queue and output.
module periodic_can_frame_scheduler
  import pcfs_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // slot[3:0], now_us[67:4], frame_id[96:68], extended[97], data_len[101:98],
  // data_bytes[165:102], period_ms[197:166], zero pad[199:198]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [ACT_W-1:0]       s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // due_slot[3:0], out_id[32:4], out_extended[33], out_len[37:34], out_data[101:38],
  // zero pad[103:102]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  pcfs_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_action_i    (s_axis_tuser_i),
    .in_slot_i      (s_axis_tdata_i[3:0]),
    .in_now_us_i    (s_axis_tdata_i[67:4]),
    .in_frame_id_i  (s_axis_tdata_i[96:68]),
    .in_extended_i  (s_axis_tdata_i[97]),
    .in_data_len_i  (s_axis_tdata_i[101:98]),
    .in_data_bytes_i(s_axis_tdata_i[165:102]),
    .in_period_ms_i (s_axis_tdata_i[197:166]),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  pcfs_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_o      (res)
  );

  assign m_axis_tdata_o = {2'b00, res.out_data, res.out_len, res.out_extended,
                           res.out_id, res.due_slot};
  assign m_axis_tlast_o = res.last;

endmodule
